// ===== rtl/vector_angle_degrees_and_length_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the vector angle and length block
// Shared property forms used by the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef VECTOR_ANGLE_DEGREES_AND_LENGTH_TOP_DEFINES_SVH
`define VECTOR_ANGLE_DEGREES_AND_LENGTH_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VADL_ASSERT_IMPL(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VADL_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/vadl_pkg.sv =====
// ----------------------------------------------------------------------------
// vadl_pkg
// Types, constants and the cosine table shared by the vector angle and
// length pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vadl_pkg;

  // Default configuration.
  localparam int COORD_BITS_DEF       = 16;
  localparam int LENGTH_FRAC_BITS_DEF = 4;

  // Result field widths.
  localparam int ANGLE_W  = 9;
  localparam int LENGTH_W = 21;

  // Angle constants in degrees.
  localparam int HALF_TURN    = 180;
  localparam int FULL_TURN    = 2 * HALF_TURN;
  localparam int QUARTER_TURN = HALF_TURN / 2;

  // Cosine table: cos(k degrees) for k = 0..89 in unsigned Q2.62.
  localparam int COS_ENTRIES  = QUARTER_TURN;
  localparam int COS_IDX_W    = $clog2(COS_ENTRIES);
  localparam int SERIES_TERMS = 16;

  // The in-quadrant degree count is found one bit per search step.
  localparam int ANGLE_STEPS = COS_IDX_W;
  localparam int STEP_STAGES = 3;
  localparam int ANGLE_LAT   = ANGLE_STEPS * STEP_STAGES + 1;

  localparam logic [63:0] PI_Q62       = 64'hC90F_DAA2_2168_C234;
  localparam logic [63:0] ONE_Q62      = 64'h4000_0000_0000_0000;
  localparam logic [63:0] DEG_STEP_Q62 = PI_Q62 / HALF_TURN;

  typedef logic [63:0] cos_q62_t;
  typedef cos_q62_t cos_tab_t [COS_ENTRIES];

  // Quadrant that the vector was turned out of.
  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_90,
    QUAD_180,
    QUAD_270
  } quad_t;

  // Angle beat leaving the search pipeline.
  typedef struct packed {
    logic               vld;
    logic               zero;
    logic [ANGLE_W-1:0] deg;
  } ang_beat_t;

  // Length beat leaving the square root pipeline.
  typedef struct packed {
    logic                vld;
    logic [LENGTH_W-1:0] len;
  } len_beat_t;

  // Q2.62 product, truncated.
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Unsigned 64-bit quotient by restoring long division, used at elaboration.
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Taylor series for cos(k degrees), evaluated at elaboration.
  function automatic cos_tab_t build_cos_tab();
    cos_tab_t    tab;
    logic [63:0] ang;
    logic [63:0] ang2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] den;
    tab[0] = ONE_Q62;
    for (int k = 1; k < COS_ENTRIES; k++) begin
      ang  = DEG_STEP_Q62 * 64'(k);
      ang2 = mul_q62(ang, ang);
      term = ONE_Q62;
      acc  = ONE_Q62;
      for (int n = 0; n < SERIES_TERMS; n++) begin
        den  = 64'((2 * n + 1) * (2 * n + 2));
        term = div_u64(mul_q62(term, ang2), den);
        if (n[0] == 1'b0) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
      tab[k] = acc;
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_Q62 = build_cos_tab();

  // Degree offset of each quadrant.
  function automatic logic [ANGLE_W-1:0] quad_base(input quad_t q);
    logic [ANGLE_W-1:0] base;
    unique case (q)
      QUAD_0:   base = '0;
      QUAD_90:  base = ANGLE_W'(QUARTER_TURN);
      QUAD_180: base = ANGLE_W'(HALF_TURN);
      QUAD_270: base = ANGLE_W'(HALF_TURN + QUARTER_TURN);
    endcase
    return base;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/vector_angle_degrees_and_length_top.sv =====
// ----------------------------------------------------------------------------
// vector_angle_degrees_and_length_top
// Difference vector of two points: length in 1/16 pixel, truncated, and
// direction as the exact floor of atan2 in whole degrees, 0..359.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                 Payload
//  input     start / busy              in_start_x, in_start_y, in_end_x, in_end_y
//  result    out_valid (one cycle)     out_angle_deg, out_length_q4, out_is_zero
//
// One beat is accepted per clock while busy is low; busy is a register that is set during reset,
// clears once it samples rst_n high, and stays low from then on.
// The depth is set by the angle search (7 steps of 3 stages plus its output
// stage) or by the square root (one stage per root bit), whichever is longer.
// Reset is synchronous and active low; it clears every valid bit in flight.
// The receiver cannot stall, so the pipeline advances on every clock.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vector_angle_degrees_and_length_top_defines.svh"

module vector_angle_degrees_and_length_top
  import vadl_pkg::*;
#(
  parameter int COORD_BITS       = COORD_BITS_DEF,
  parameter int LENGTH_FRAC_BITS = LENGTH_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  output logic                         out_valid,
  output logic [ANGLE_W-1:0]           out_angle_deg,
  output logic [LENGTH_W-1:0]          out_length_q4,
  output logic                         out_is_zero
);

  localparam int DIFF_W    = COORD_BITS + 1;
  localparam int SQ_W      = 2 * COORD_BITS;
  localparam int SUM_W     = SQ_W + 1;
  localparam int ROOT_W    = COORD_BITS + LENGTH_FRAC_BITS + 1;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int PIPE_LAT  = (ANGLE_LAT > ROOT_W) ? ANGLE_LAT : ROOT_W;
  localparam int ANG_PAD   = PIPE_LAT - ANGLE_LAT;
  localparam int LEN_PAD   = PIPE_LAT - ROOT_W;
  localparam int TOTAL_LAT = 4 + PIPE_LAT + 1;

  // Busy only while reset holds the pipeline.
  logic busy_r;
  logic in_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy    = busy_r;
  assign in_fire = start && !busy_r;

  // Stage 1: difference vector, one bit wider than the coordinates.
  logic                     s1_vld_r;
  logic signed [DIFF_W-1:0] s1_dx_r;
  logic signed [DIFF_W-1:0] s1_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    s1_dx_r <= DIFF_W'(in_end_x) - DIFF_W'(in_start_x);
    s1_dy_r <= DIFF_W'(in_end_y) - DIFF_W'(in_start_y);
  end

  // Stage 2: turn a nonzero vector by a multiple of 90 degrees into u > 0, v >= 0.
  logic                  dx_neg;
  logic                  dy_neg;
  logic                  dx_zero;
  logic                  dy_zero;
  logic [COORD_BITS-1:0] ax_nxt;
  logic [COORD_BITS-1:0] ay_nxt;
  logic [COORD_BITS-1:0] u_nxt;
  logic [COORD_BITS-1:0] v_nxt;
  quad_t                 quad_nxt;

  always_comb begin
    dx_neg  = s1_dx_r[DIFF_W-1];
    dy_neg  = s1_dy_r[DIFF_W-1];
    dx_zero = (s1_dx_r == '0);
    dy_zero = (s1_dy_r == '0);
    ax_nxt  = dx_neg ? COORD_BITS'(-s1_dx_r) : COORD_BITS'(s1_dx_r);
    ay_nxt  = dy_neg ? COORD_BITS'(-s1_dy_r) : COORD_BITS'(s1_dy_r);
    priority if (!dx_neg && !dx_zero && !dy_neg) begin
      u_nxt    = ax_nxt;
      v_nxt    = ay_nxt;
      quad_nxt = QUAD_0;
    end else if ((dx_neg || dx_zero) && !dy_neg && !dy_zero) begin
      u_nxt    = ay_nxt;
      v_nxt    = ax_nxt;
      quad_nxt = QUAD_90;
    end else if (dx_neg && (dy_neg || dy_zero)) begin
      u_nxt    = ax_nxt;
      v_nxt    = ay_nxt;
      quad_nxt = QUAD_180;
    end else begin
      u_nxt    = ay_nxt;
      v_nxt    = ax_nxt;
      quad_nxt = QUAD_270;
    end
  end

  logic                  s2_vld_r;
  logic [COORD_BITS-1:0] s2_u_r;
  logic [COORD_BITS-1:0] s2_v_r;
  quad_t                 s2_quad_r;
  logic                  s2_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_u_r    <= u_nxt;
    s2_v_r    <= v_nxt;
    s2_quad_r <= quad_nxt;
    s2_zero_r <= dx_zero && dy_zero;
  end

  // Stage 3: squares of both components.
  logic                  s3_vld_r;
  logic [SQ_W-1:0]       s3_sq_u_r;
  logic [SQ_W-1:0]       s3_sq_v_r;
  logic [COORD_BITS-1:0] s3_u_r;
  logic [COORD_BITS-1:0] s3_v_r;
  quad_t                 s3_quad_r;
  logic                  s3_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_sq_u_r <= SQ_W'(s2_u_r) * SQ_W'(s2_u_r);
    s3_sq_v_r <= SQ_W'(s2_v_r) * SQ_W'(s2_v_r);
    s3_u_r    <= s2_u_r;
    s3_v_r    <= s2_v_r;
    s3_quad_r <= s2_quad_r;
    s3_zero_r <= s2_zero_r;
  end

  // Stage 4: squared length.
  logic                  s4_vld_r;
  logic [SUM_W-1:0]      s4_sum_r;
  logic [COORD_BITS-1:0] s4_u_r;
  logic [COORD_BITS-1:0] s4_v_r;
  quad_t                 s4_quad_r;
  logic                  s4_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_sum_r  <= SUM_W'(s3_sq_u_r) + SUM_W'(s3_sq_v_r);
    s4_u_r    <= s3_u_r;
    s4_v_r    <= s3_v_r;
    s4_quad_r <= s3_quad_r;
    s4_zero_r <= s3_zero_r;
  end

  // Angle search and square root run side by side.
  ang_beat_t          ang_beat;
  logic               root_vld;
  logic [ROOT_W-1:0]  root;
  logic [RAD_W-1:0]   rad;
  len_beat_t          len_beat;

  vadl_angle #(
    .COORD_BITS (COORD_BITS)
  ) u_angle (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s4_vld_r),
    .in_u     (s4_u_r),
    .in_v     (s4_v_r),
    .in_quad  (s4_quad_r),
    .in_zero  (s4_zero_r),
    .out_beat (ang_beat)
  );

  assign rad = RAD_W'(s4_sum_r) << (2 * LENGTH_FRAC_BITS);

  vadl_sqrt #(
    .ROOT_W (ROOT_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s4_vld_r),
    .in_rad    (rad),
    .out_valid (root_vld),
    .out_root  (root)
  );

  assign len_beat.vld = root_vld;
  assign len_beat.len = LENGTH_W'(root);

  // Delay the shorter path so that both beats line up.
  ang_beat_t ang_al;
  len_beat_t len_al;

  if (ANG_PAD == 0) begin : g_ang_direct
    assign ang_al = ang_beat;
  end else begin : g_ang_pad
    ang_beat_t pad_r [ANG_PAD];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        for (int i = 0; i < ANG_PAD; i++) begin
          pad_r[i] <= '0;
        end
      end else begin
        pad_r[0] <= ang_beat;
        for (int i = 1; i < ANG_PAD; i++) begin
          pad_r[i] <= pad_r[i-1];
        end
      end
    end

    assign ang_al = pad_r[ANG_PAD-1];
  end

  if (LEN_PAD == 0) begin : g_len_direct
    assign len_al = len_beat;
  end else begin : g_len_pad
    len_beat_t pad_r [LEN_PAD];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        for (int i = 0; i < LEN_PAD; i++) begin
          pad_r[i] <= '0;
        end
      end else begin
        pad_r[0] <= len_beat;
        for (int i = 1; i < LEN_PAD; i++) begin
          pad_r[i] <= pad_r[i-1];
        end
      end
    end

    assign len_al = pad_r[LEN_PAD-1];
  end

  // Output register: one strobed beat per accepted item.
  logic                out_valid_r;
  logic [ANGLE_W-1:0]  out_angle_deg_r;
  logic [LENGTH_W-1:0] out_length_q4_r;
  logic                out_is_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= len_al.vld;
    end
  end

  always_ff @(posedge clk) begin
    out_angle_deg_r <= ang_al.deg;
    out_length_q4_r <= len_al.len;
    out_is_zero_r   <= ang_al.zero;
  end

  assign out_valid     = out_valid_r;
  assign out_angle_deg = out_angle_deg_r;
  assign out_length_q4 = out_length_q4_r;
  assign out_is_zero   = out_is_zero_r;

  // Checks on the block's own pipeline.
  `VADL_ASSERT_IMPL(a_paths_aligned, clk, rst_n, 1'b1, ang_al.vld == len_al.vld, "angle and length beats out of step")
  `VADL_ASSERT_IMPL(a_angle_range, clk, rst_n, out_valid, out_angle_deg < FULL_TURN, "angle beyond a full turn")
  `VADL_ASSERT_IMPL(a_zero_result, clk, rst_n, out_valid && out_is_zero, (out_angle_deg == '0) && (out_length_q4 == '0), "zero vector with nonzero result")
  `VADL_ASSERT_IMPL(a_latency, clk, rst_n, in_fire, ##TOTAL_LAT out_valid, "accepted beat did not come out on time")
  `VADL_ASSERT_NEXT(a_never_busy, clk, rst_n, !busy, !busy, "busy raised outside reset")

endmodule

`default_nettype wire

// ===== rtl/vadl_sqrt.sv =====
// ----------------------------------------------------------------------------
// vadl_sqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vadl_sqrt
  import vadl_pkg::*;
#(
  parameter int ROOT_W = COORD_BITS_DEF + LENGTH_FRAC_BITS_DEF + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [2*ROOT_W-1:0]   in_rad,
  output logic                  out_valid,
  output logic [ROOT_W-1:0]     out_root
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 3;

  // Stage boundaries: index j feeds stage j.
  logic              st_vld  [ROOT_W+1];
  logic [ROOT_W-1:0] st_root [ROOT_W+1];
  logic [RAD_W-1:0]  st_rad  [ROOT_W];
  logic [REM_W-1:0]  st_rem  [ROOT_W];

  assign st_vld[0]  = in_valid;
  assign st_root[0] = '0;
  assign st_rad[0]  = in_rad;
  assign st_rem[0]  = '0;

  for (genvar j = 0; j < ROOT_W; j++) begin : g_bit
    logic [REM_W-1:0]  shifted_nxt;
    logic [REM_W-1:0]  trial_nxt;
    logic              ge_nxt;
    logic [ROOT_W-1:0] root_nxt;
    logic              vld_r;
    logic [ROOT_W-1:0] root_r;

    // Bring down the next two radicand bits and try the next root bit.
    always_comb begin
      shifted_nxt = {st_rem[j][REM_W-3:0], st_rad[j][RAD_W-1-2*j -: 2]};
      trial_nxt   = REM_W'({st_root[j], 2'b01});
      ge_nxt      = (shifted_nxt >= trial_nxt);
      root_nxt    = {st_root[j][ROOT_W-2:0], ge_nxt};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else begin
        vld_r <= st_vld[j];
      end
    end

    always_ff @(posedge clk) begin
      root_r <= root_nxt;
    end

    assign st_vld[j+1]  = vld_r;
    assign st_root[j+1] = root_r;

    // The remainder and radicand go on only to stages that still need them.
    if (j < ROOT_W - 1) begin : g_carry
      logic [REM_W-1:0] rem_nxt;
      logic [REM_W-1:0] rem_r;
      logic [RAD_W-1:0] rad_r;

      assign rem_nxt = ge_nxt ? (shifted_nxt - trial_nxt) : shifted_nxt;

      always_ff @(posedge clk) begin
        rem_r <= rem_nxt;
        rad_r <= st_rad[j];
      end

      assign st_rem[j+1] = rem_r;
      assign st_rad[j+1] = rad_r;
    end
  end

  assign out_valid = st_vld[ROOT_W];
  assign out_root  = st_root[ROOT_W];

endmodule

`default_nettype wire

// ===== rtl/vadl_angle.sv =====
// ----------------------------------------------------------------------------
// vadl_angle
// Pipelined binary search for the whole-degree direction inside a quadrant,
// with exact Q2.62 cross products, three register stages per search step.
// ----------------------------------------------------------------------------
`default_nettype none

module vadl_angle
  import vadl_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [COORD_BITS-1:0] in_u,
  input  logic [COORD_BITS-1:0] in_v,
  input  quad_t                 in_quad,
  input  logic                  in_zero,
  output ang_beat_t             out_beat
);

  localparam int PP_W = COORD_BITS + 32;
  localparam int PR_W = COORD_BITS + 64;

  // Step boundaries: index j feeds search step j.
  logic                 s_vld  [ANGLE_STEPS+1];
  logic                 s_zero [ANGLE_STEPS+1];
  quad_t                s_quad [ANGLE_STEPS+1];
  logic [COS_IDX_W-1:0] s_cnt  [ANGLE_STEPS+1];
  logic [COORD_BITS-1:0] s_u   [ANGLE_STEPS];
  logic [COORD_BITS-1:0] s_v   [ANGLE_STEPS];

  assign s_vld[0]  = in_valid;
  assign s_zero[0] = in_zero;
  assign s_quad[0] = in_quad;
  assign s_cnt[0]  = '0;
  assign s_u[0]    = in_u;
  assign s_v[0]    = in_v;

  for (genvar j = 0; j < ANGLE_STEPS; j++) begin : g_step
    localparam logic [COS_IDX_W-1:0] STEP_BIT = COS_IDX_W'(1) << (ANGLE_STEPS - 1 - j);

    logic [COS_IDX_W-1:0]  trial_nxt;
    logic                  ok_nxt;
    logic [COS_IDX_W-1:0]  idx_c_nxt;
    logic [COS_IDX_W-1:0]  idx_s_nxt;

    logic                  a_vld_r;
    logic                  a_ok_r;
    logic                  a_zero_r;
    quad_t                 a_quad_r;
    logic [COS_IDX_W-1:0]  a_cnt_r;
    logic [COS_IDX_W-1:0]  a_trial_r;
    logic [COORD_BITS-1:0] a_u_r;
    logic [COORD_BITS-1:0] a_v_r;
    cos_q62_t              a_cos_r;
    cos_q62_t              a_sin_r;

    logic                  b_vld_r;
    logic                  b_ok_r;
    logic                  b_zero_r;
    quad_t                 b_quad_r;
    logic [COS_IDX_W-1:0]  b_cnt_r;
    logic [COS_IDX_W-1:0]  b_trial_r;
    logic [PP_W-1:0]       b_vh_r;
    logic [PP_W-1:0]       b_vl_r;
    logic [PP_W-1:0]       b_uh_r;
    logic [PP_W-1:0]       b_ul_r;

    logic [PR_W-1:0]       prod_v_nxt;
    logic [PR_W-1:0]       prod_u_nxt;
    logic [COS_IDX_W-1:0]  cnt_nxt;

    logic                  c_vld_r;
    logic                  c_zero_r;
    quad_t                 c_quad_r;
    logic [COS_IDX_W-1:0]  c_cnt_r;

    // Stage a: set the next count bit and fetch cos and sin of the trial.
    always_comb begin
      trial_nxt = s_cnt[j] | STEP_BIT;
      ok_nxt    = (trial_nxt < COS_IDX_W'(QUARTER_TURN));
      idx_c_nxt = ok_nxt ? trial_nxt : '0;
      idx_s_nxt = ok_nxt ? (COS_IDX_W'(QUARTER_TURN) - trial_nxt) : '0;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_vld_r <= 1'b0;
      end else begin
        a_vld_r <= s_vld[j];
      end
    end

    always_ff @(posedge clk) begin
      a_ok_r    <= ok_nxt;
      a_zero_r  <= s_zero[j];
      a_quad_r  <= s_quad[j];
      a_cnt_r   <= s_cnt[j];
      a_trial_r <= trial_nxt;
      a_u_r     <= s_u[j];
      a_v_r     <= s_v[j];
      a_cos_r   <= COS_Q62[idx_c_nxt];
      a_sin_r   <= COS_Q62[idx_s_nxt];
    end

    // Stage b: partial products of v*cos and u*sin on 32-bit halves.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        b_vld_r <= 1'b0;
      end else begin
        b_vld_r <= a_vld_r;
      end
    end

    always_ff @(posedge clk) begin
      b_ok_r    <= a_ok_r;
      b_zero_r  <= a_zero_r;
      b_quad_r  <= a_quad_r;
      b_cnt_r   <= a_cnt_r;
      b_trial_r <= a_trial_r;
      b_vh_r    <= PP_W'(a_v_r) * PP_W'(a_cos_r[63:32]);
      b_vl_r    <= PP_W'(a_v_r) * PP_W'(a_cos_r[31:0]);
      b_uh_r    <= PP_W'(a_u_r) * PP_W'(a_sin_r[63:32]);
      b_ul_r    <= PP_W'(a_u_r) * PP_W'(a_sin_r[31:0]);
    end

    // Stage c: keep the trial bit when the vector lies at or past it.
    always_comb begin
      prod_v_nxt = (PR_W'(b_vh_r) << 32) + PR_W'(b_vl_r);
      prod_u_nxt = (PR_W'(b_uh_r) << 32) + PR_W'(b_ul_r);
      cnt_nxt    = (b_ok_r && (prod_v_nxt >= prod_u_nxt)) ? b_trial_r : b_cnt_r;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        c_vld_r <= 1'b0;
      end else begin
        c_vld_r <= b_vld_r;
      end
    end

    always_ff @(posedge clk) begin
      c_zero_r <= b_zero_r;
      c_quad_r <= b_quad_r;
      c_cnt_r  <= cnt_nxt;
    end

    assign s_vld[j+1]  = c_vld_r;
    assign s_zero[j+1] = c_zero_r;
    assign s_quad[j+1] = c_quad_r;
    assign s_cnt[j+1]  = c_cnt_r;

    // The vector itself goes on only to steps that still need it.
    if (j < ANGLE_STEPS - 1) begin : g_carry
      logic [COORD_BITS-1:0] b_u_r;
      logic [COORD_BITS-1:0] b_v_r;
      logic [COORD_BITS-1:0] c_u_r;
      logic [COORD_BITS-1:0] c_v_r;

      always_ff @(posedge clk) begin
        b_u_r <= a_u_r;
        b_v_r <= a_v_r;
        c_u_r <= b_u_r;
        c_v_r <= b_v_r;
      end

      assign s_u[j+1] = c_u_r;
      assign s_v[j+1] = c_v_r;
    end
  end

  // Output stage: add the quadrant base; a zero vector reads as 0 degrees.
  ang_beat_t beat_nxt;
  ang_beat_t beat_r;

  always_comb begin
    beat_nxt.vld  = s_vld[ANGLE_STEPS];
    beat_nxt.zero = s_zero[ANGLE_STEPS];
    beat_nxt.deg  = s_zero[ANGLE_STEPS] ? '0 :
                    (quad_base(s_quad[ANGLE_STEPS]) + ANGLE_W'(s_cnt[ANGLE_STEPS]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.vld <= 1'b0;
    end else begin
      beat_r.vld <= beat_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    beat_r.zero <= beat_nxt.zero;
    beat_r.deg  <= beat_nxt.deg;
  end

  assign out_beat = beat_r;

endmodule

`default_nettype wire
